### hw/rtl/grp_pkg.sv
// Shared types and constants for the guillotine rectangle packer.
package grp_pkg;

    localparam int CfgW = 13;
    localparam int PadW = 8;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NOFIT = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        REG_ATLAS_W = 2'd0,
        REG_ATLAS_H = 2'd1,
        REG_PADDING = 2'd2
    } cfg_idx_t;

    localparam logic REQ_PLACE = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [12:0] sprite_width;
        logic [12:0] sprite_height;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] pos_x;
        logic [11:0] pos_y;
    } rsp_t;

endpackage

### hw/rtl/grp_mem.sv
// Synchronous single-port-write, single-port-read memory with registered read data.
module grp_mem #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### hw/rtl/guillotine_rect_packer.sv
// Guillotine rectangle packer: one request in, one result out. The split tree
// lives in a node store with registered reads, and the depth-first walk keeps
// pending second children in a stack memory. Every node visited passes a read
// state (S_RD or S_PREAD) and then a decide state (S_EVAL), and every split
// writes its two children in the states S_WA and S_WB; a place makes at most
// two splits. A clear loads its result in S_CLR once the result register is
// free. A new request is taken whenever the walk is idle, even while the
// previous result still waits; the walk then holds at its last step until the
// result register is free. The reset root is written in S_INIT, the state that
// reset leaves the walk in. The atlas size takes effect at the next clear; the
// padding applies from the next place request.
module guillotine_rect_packer #(
    parameter int MAX_NODES = 1024,
    parameter int COORD_MAX = 4096
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [12:0]          cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  grp_pkg::req_t        s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output grp_pkg::rsp_t        m_data
);
    import grp_pkg::*;

    localparam int AW = $clog2(MAX_NODES);
    localparam int CW = $clog2(COORD_MAX + 1);
    localparam int NW = AW + 1;
    // padded sprite sizes: widest of coordinate and sprite field, plus two bits for the padding
    localparam int PW = ((CW > CfgW) ? CW : CfgW) + 2;
    // node: x, y, w, h, used, split, kid
    localparam int EW = 4 * CW + 2 + AW;
    localparam logic [CW-1:0] CMAX = CW'(COORD_MAX);
    localparam logic [NW:0]   NMAX = (NW+1)'(MAX_NODES);

    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [CW-1:0] w;
        logic [CW-1:0] h;
        logic          used;
        logic          split;
        logic [AW-1:0] kid;
    } node_t;

    typedef enum logic [2:0] {
        S_INIT, S_IDLE, S_CLR, S_RD, S_PREAD, S_EVAL, S_WA, S_WB
    } state_t;

    logic [CfgW-1:0] aw_reg, ah_reg;
    logic [PadW-1:0] pad_reg;
    state_t          state_reg;
    logic [NW-1:0]   count_reg;
    logic [NW-1:0]   sp_reg;
    logic [AW-1:0]   cur_reg;
    logic [PW-1:0]   pw_reg, ph_reg;
    logic            split_go_reg;
    node_t           ca_reg, cb_reg;
    logic            out_valid_reg;
    rsp_t            out_reg;
    logic            out_valid_next;
    rsp_t            out_next;
    logic            res_load;

    logic            nwe;
    logic [AW-1:0]   nwaddr, nraddr;
    node_t           nwdata;
    logic [EW-1:0]   nrdata;
    logic            swe;
    logic [AW-1:0]   swaddr, sraddr;
    logic [AW-1:0]   swdata, srdata;
    node_t           rd;
    node_t           root;

    grp_mem #(.DEPTH(MAX_NODES), .WIDTH(EW)) u_nodes (
        .aclk(aclk), .we(nwe), .waddr(nwaddr), .wdata(nwdata),
        .raddr(nraddr), .rdata(nrdata)
    );
    grp_mem #(.DEPTH(MAX_NODES), .WIDTH(AW)) u_stack (
        .aclk(aclk), .we(swe), .waddr(swaddr), .wdata(swdata),
        .raddr(sraddr), .rdata(srdata)
    );

    assign rd = node_t'(nrdata);

    function automatic logic [CW-1:0] sat(input logic [CfgW-1:0] v);
        return (32'(v) > 32'(COORD_MAX)) ? CMAX : CW'(v);
    endfunction

    assign root = '{x: '0, y: '0, w: sat(aw_reg), h: sat(ah_reg),
                    used: 1'b0, split: 1'b0, kid: '0};

    // Decision on the node just read
    logic [PW-1:0] lw, lh, sw, sh;
    logic          fit_exact, too_big, one_axis, do_hsplit;
    logic [NW:0]   need;
    logic          is_leaf, skip, hit, store_full, stack_full, grow;
    logic          ends_walk, out_free;
    assign lw = PW'(rd.w);
    assign lh = PW'(rd.h);
    assign fit_exact = (pw_reg == lw) && (ph_reg == lh);
    assign too_big = (pw_reg > lw) || (ph_reg > lh);
    assign one_axis = (pw_reg == lw) || (ph_reg == lh);
    assign need = (NW+1)'(count_reg) + (one_axis ? (NW+1)'(2) : (NW+1)'(4));
    assign sw = lw - pw_reg;
    assign sh = lh - ph_reg;
    assign do_hsplit = (sw <= sh);
    assign is_leaf = !rd.split;
    assign skip = is_leaf && (rd.used || too_big);
    assign hit = is_leaf && !rd.used && fit_exact;
    // room for every node of the split is checked once, at the first leaf
    assign store_full = is_leaf && !rd.used && !fit_exact && !too_big
                        && !split_go_reg && (need > NMAX);
    assign grow = is_leaf && !skip && !fit_exact && !store_full;
    assign stack_full = rd.split && (((NW+1)'(sp_reg) + (NW+1)'(2)) > NMAX);
    assign ends_walk = hit || store_full || stack_full || (skip && sp_reg == '0);
    assign out_free = !out_valid_reg || m_ready;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = out_valid_reg;
    assign m_data = out_reg;

    always_comb begin
        res_load = 1'b0;
        out_next = '{status: ST_NOFIT, pos_x: '0, pos_y: '0};
        case (state_reg)
            S_CLR: begin
                res_load = out_free;
                out_next.status = ST_OK;
            end
            S_EVAL: begin
                res_load = ends_walk && out_free;
                if (hit) begin
                    out_next = '{status: ST_OK, pos_x: 12'(rd.x), pos_y: 12'(rd.y)};
                end else if (store_full || stack_full) begin
                    out_next.status = ST_FULL;
                end
            end
            default: ;
        endcase
        out_valid_next = res_load || (out_valid_reg && !m_ready);
    end

    always_comb begin
        nwe = 1'b0;
        nwaddr = cur_reg;
        nwdata = rd;
        nraddr = cur_reg;
        swe = 1'b0;
        swaddr = sp_reg[AW-1:0];
        swdata = rd.kid + AW'(1);
        sraddr = AW'(sp_reg - NW'(1));
        case (state_reg)
            S_INIT: begin
                nwe = 1'b1;
                nwaddr = '0;
                nwdata = root;
            end
            S_CLR: begin
                nwe = out_free;
                nwaddr = '0;
                nwdata = root;
            end
            S_PREAD: begin
                // popped index goes straight to the node store
                nraddr = srdata;
            end
            S_EVAL: begin
                swe = rd.split && !stack_full;
                if (hit && out_free) begin
                    nwe = 1'b1;
                    nwdata.used = 1'b1;
                end else if (grow) begin
                    nwe = 1'b1;
                    nwdata.split = 1'b1;
                    nwdata.kid = count_reg[AW-1:0];
                end
            end
            S_WA: begin
                nwe = 1'b1;
                nwdata = ca_reg;
            end
            S_WB: begin
                nwe = 1'b1;
                nwaddr = cur_reg + AW'(1);
                nwdata = cb_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            aw_reg <= CfgW'(1024);
            ah_reg <= CfgW'(1024);
            pad_reg <= '0;
            state_reg <= S_INIT;
            count_reg <= NW'(1);
            sp_reg <= '0;
            cur_reg <= '0;
            split_go_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_ATLAS_W: aw_reg <= cfg_wdata;
                    REG_ATLAS_H: ah_reg <= cfg_wdata;
                    REG_PADDING: pad_reg <= cfg_wdata[PadW-1:0];
                    default: ;
                endcase
            end
            out_valid_reg <= out_valid_next;
            if (res_load) begin
                out_reg <= out_next;
                split_go_reg <= 1'b0;
            end
            case (state_reg)
                S_INIT: begin
                    state_reg <= S_IDLE;
                end
                S_IDLE: begin
                    if (s_valid && s_ready) begin
                        if (s_data.req_type == REQ_CLEAR) begin
                            state_reg <= S_CLR;
                        end else begin
                            pw_reg <= PW'(s_data.sprite_width) + PW'({pad_reg, 1'b0});
                            ph_reg <= PW'(s_data.sprite_height) + PW'({pad_reg, 1'b0});
                            cur_reg <= '0;
                            sp_reg <= '0;
                            state_reg <= S_RD;
                        end
                    end
                end
                S_CLR: begin
                    if (res_load) begin
                        count_reg <= NW'(1);
                        state_reg <= S_IDLE;
                    end
                end
                S_RD: begin
                    state_reg <= S_EVAL;
                end
                S_PREAD: begin
                    cur_reg <= srdata;
                    state_reg <= S_EVAL;
                end
                S_EVAL: begin
                    // a finished walk holds here until the result register frees
                    if (res_load) begin
                        state_reg <= S_IDLE;
                    end else if (rd.split) begin
                        if (!stack_full) begin
                            // second child stacked; first child visited next
                            sp_reg <= sp_reg + NW'(1);
                            cur_reg <= rd.kid;
                            state_reg <= S_RD;
                        end
                    end else if (skip) begin
                        if (sp_reg != '0) begin
                            sp_reg <= sp_reg - NW'(1);
                            state_reg <= S_PREAD;
                        end
                    end else if (grow) begin
                        count_reg <= count_reg + NW'(2);
                        cur_reg <= count_reg[AW-1:0];
                        split_go_reg <= 1'b1;
                        if (do_hsplit) begin
                            ca_reg <= '{x: rd.x, y: rd.y, w: rd.w,
                                        h: CW'(ph_reg), used: 1'b0,
                                        split: 1'b0, kid: '0};
                            cb_reg <= '{x: rd.x, y: rd.y + CW'(ph_reg),
                                        w: rd.w, h: CW'(sh), used: 1'b0,
                                        split: 1'b0, kid: '0};
                        end else begin
                            ca_reg <= '{x: rd.x, y: rd.y, w: CW'(pw_reg),
                                        h: rd.h, used: 1'b0,
                                        split: 1'b0, kid: '0};
                            cb_reg <= '{x: rd.x + CW'(pw_reg), y: rd.y,
                                        w: CW'(sw), h: rd.h, used: 1'b0,
                                        split: 1'b0, kid: '0};
                        end
                        state_reg <= S_WA;
                    end
                end
                S_WA: begin
                    state_reg <= S_WB;
                end
                S_WB: begin
                    state_reg <= S_RD;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    property p_hold;
        @(posedge aclk) disable iff (!aresetn)
            out_valid_reg && !m_ready |=> out_valid_reg && $stable(out_reg);
    endproperty
    a_hold: assert property (p_hold) else $error("result changed while stalled");

    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (NW+1)'(count_reg) <= NMAX) else $error("node count overflow");

    a_stack: assert property (@(posedge aclk) disable iff (!aresetn)
        (NW+1)'(sp_reg) <= NMAX) else $error("search stack overflow");
endmodule
